// ===== design/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the streaming substring substitute block.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Bytes a single job can carry: the larger of a full window or a replacement
  localparam int JOB_BYTES = 8;
  // Width of a byte count within a job (0..JOB_BYTES)
  localparam int CNT_W = 4;
  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  // Register map, one 64-bit register every 8 bytes
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH     = 3'd0,
    REG_PATTERN_BYTES      = 3'd1,
    REG_REPLACEMENT_LENGTH = 3'd2,
    REG_REPLACEMENT_BYTES  = 3'd3,
    REG_INSTANCE_SELECT    = 3'd4
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [3:0]  pattern_length;
    logic [63:0] pattern_bytes;
    logic [3:0]  replacement_length;
    logic [63:0] replacement_bytes;
    logic [15:0] instance_select;
  } cfg_t;

  // One unit of output work: cnt bytes of data, or a bare end marker when
  // cnt is zero and text_end is set
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] data;
    logic [CNT_W-1:0]          cnt;
    logic                      text_end;
  } job_t;

endpackage

// ===== design/sss_cfg.sv =====
// ----------------------------------------------------------------------------
// sss_cfg
// APB register file holding the search pattern, replacement and selector.
// ----------------------------------------------------------------------------
module sss_cfg
  import sss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              plen_wr
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;

  // Pulse so the front drops its window on a new pattern length
  assign plen_wr = wr_en && (idx == REG_PATTERN_LENGTH);

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PATTERN_LENGTH:     cfg.pattern_length     <= pwdata[3:0];
        REG_PATTERN_BYTES:      cfg.pattern_bytes      <= pwdata;
        REG_REPLACEMENT_LENGTH: cfg.replacement_length <= pwdata[3:0];
        REG_REPLACEMENT_BYTES:  cfg.replacement_bytes  <= pwdata;
        REG_INSTANCE_SELECT:    cfg.instance_select    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_PATTERN_LENGTH:     prdata = {60'd0, cfg.pattern_length};
      REG_PATTERN_BYTES:      prdata = cfg.pattern_bytes;
      REG_REPLACEMENT_LENGTH: prdata = {60'd0, cfg.replacement_length};
      REG_REPLACEMENT_BYTES:  prdata = cfg.replacement_bytes;
      REG_INSTANCE_SELECT:    prdata = {48'd0, cfg.instance_select};
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== design/sss_front.sv =====
// ----------------------------------------------------------------------------
// sss_front
// Accepts text bytes, keeps the match window and match count, and turns each
// byte into at most one job: one byte, the replacement, or a window flush.
// ----------------------------------------------------------------------------
module sss_front
  import sss_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       plen_wr,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0][7:0] win;
  logic [PATTERN_MAX-1:0][7:0] win_next;
  logic [PATTERN_MAX-1:0][7:0] win_app;
  logic [PATTERN_MAX-1:0][7:0] win_sh;
  logic [FILL_W-1:0]           fill;
  logic [FILL_W-1:0]           fill_next;
  logic [FILL_W-1:0]           fill_base;
  logic [FILL_W-1:0]           fill_app;
  logic [15:0]                 match_count;
  logic [15:0]                 match_count_next;
  logic [3:0]                  plen;
  logic [3:0]                  rlen;
  logic                        full;
  logic                        same;
  logic                        hit;
  logic                        take;
  logic                        need;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign q_push   = take && need;

  // Clamp lengths to what the hardware holds
  assign plen = (cfg.pattern_length > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : cfg.pattern_length;
  assign rlen = (cfg.replacement_length > 4'(REPLACE_MAX)) ? 4'(REPLACE_MAX)
                                                           : cfg.replacement_length;

  // Append the new byte and compare the window against the pattern
  always_comb begin
    fill_base = (4'(fill) >= plen) ? '0 : fill;
    fill_app  = fill_base + FILL_W'(1);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_app[i] = (FILL_W'(i) == fill_base) ? in_byte : win[i];
    end
    for (int i = 0; i < PATTERN_MAX - 1; i++) begin
      win_sh[i] = win_app[i+1];
    end
    win_sh[PATTERN_MAX-1] = win_app[PATTERN_MAX-1];
    full = (4'(fill_app) == plen);
    same = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((4'(i) < plen) && (win_app[i] != cfg.pattern_bytes[8*i +: 8])) begin
        same = 1'b0;
      end
    end
    hit = (cfg.instance_select == 16'd0) || (cfg.instance_select == match_count);
  end

  // Classify the byte into a job and work out the next window state
  always_comb begin
    q_job.data = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      q_job.data[i] = win_app[i];
    end
    q_job.cnt        = '0;
    q_job.text_end   = in_end;
    win_next         = win;
    fill_next        = fill;
    match_count_next = match_count;
    if (plen == 4'd0) begin
      q_job.data[0] = in_byte;
      q_job.cnt     = CNT_W'(1);
    end else begin
      win_next  = win_app;
      fill_next = fill_app;
      if (full) begin
        if (same && (match_count != 16'hFFFF)) begin
          match_count_next = match_count + 16'd1;
        end
        if (same && hit) begin
          q_job.data = cfg.replacement_bytes;
          q_job.cnt  = rlen;
          fill_next  = '0;
        end else begin
          win_next  = win_sh;
          fill_next = fill_app - FILL_W'(1);
          q_job.cnt = in_end ? CNT_W'(fill_app) : CNT_W'(1);
        end
      end else if (in_end) begin
        q_job.cnt = CNT_W'(fill_app);
      end
    end
    if (in_end) begin
      fill_next        = '0;
      match_count_next = 16'd1;
    end
    need = in_end || (q_job.cnt != '0);
  end

  // Hold window bytes; no reset needed on the data
  always_ff @(posedge clk) begin
    if (take) begin
      win <= win_next;
    end
  end

  // Advance fill and match count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      match_count <= 16'd1;
    end else if (plen_wr) begin
      fill <= '0;
    end else if (take) begin
      fill        <= fill_next;
      match_count <= match_count_next;
    end
  end

endmodule

// ===== design/sss_queue.sv =====
// ----------------------------------------------------------------------------
// sss_queue
// Short job queue that decouples the front from the output side.
// ----------------------------------------------------------------------------
module sss_queue
  import sss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Store jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/sss_back.sv =====
// ----------------------------------------------------------------------------
// sss_back
// Expands the job at the head of the queue into output words, one per cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module sss_back
  import sss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_text_done
);

  localparam int IDX_W = $clog2(JOB_BYTES);

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             last;

  // Last word of the job: the one at count minus one, or a bare end marker
  assign last    = (job.cnt == '0) || (CNT_W'(idx) == job.cnt - CNT_W'(1));
  assign load    = job_valid && (!out_valid || out_ready);
  assign job_pop = load && last;

  // Step through the job's bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= last ? '0 : idx + IDX_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= (job.cnt == '0) ? 8'd0 : job.data[idx];
      out_byte_valid <= (job.cnt != '0);
      out_run_last   <= last;
      out_text_done  <= last && job.text_end;
    end
  end

endmodule

// ===== design/stream_substring_substitute.sv =====
// Each input byte's job passes through the job queue, then the output register.
// Throughput: one input byte per cycle while the queue is not full; the output
// side gives one word per cycle while m_tready is high, so a long replacement or
// end-of-text flush keeps it busy while a 4-job queue takes input until full.
// Reset: synchronous, active high; clears registers, window fill, match count
// (to one), the job queue and the output register. No clearing pass.
// ----------------------------------------------------------------------------
// stream_substring_substitute
// Streaming find-and-replace of a configured byte pattern in a text stream.
// ----------------------------------------------------------------------------
module stream_substring_substitute
  import sss_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] text_byte
  input  logic              s_tlast,   // end_of_text
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast,   // run_last
  output logic [1:0]        m_tuser,   // [0] byte_valid, [1] text_done
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  logic plen_wr;
  logic q_full;
  logic q_push;
  job_t q_in;
  logic q_pop;
  logic q_not_empty;
  job_t q_head;
  logic byte_valid;
  logic text_done;

  // Register file
  sss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .plen_wr (plen_wr)
  );

  // Window, match and classification
  sss_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .plen_wr  (plen_wr),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_end   (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_in)
  );

  // Job queue
  sss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Output expansion
  sss_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_not_empty),
    .job            (q_head),
    .job_pop        (q_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (m_tdata),
    .out_byte_valid (byte_valid),
    .out_run_last   (m_tlast),
    .out_text_done  (text_done)
  );

  assign m_tuser = {text_done, byte_valid};

endmodule

// ===== verif/sss_result_check.sv =====
// ----------------------------------------------------------------------------
// sss_result_check
// Watches the text stream, the substituted stream and the register port of
// the substring substitute block. Predicts the output words for every byte
// taken in and compares each word that leaves the block with the oldest
// prediction. Mismatch count and the number of words still owed go to the
// test top.
// ----------------------------------------------------------------------------
module sss_result_check
  import sss_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] text_byte
  input  logic              s_tlast,   // end_of_text
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [7:0]        m_tdata,   // [7:0] out_byte
  input  logic              m_tlast,   // run_last
  input  logic [1:0]        m_tuser,   // [0] byte_valid, [1] text_done
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                words_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MISMATCH_REPORTS = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_done;
  } out_word_t;

  // Predicted block state
  cfg_t        cfg;
  logic [7:0]  window [PATTERN_MAX];
  int          window_fill;
  logic [15:0] match_count;

  // Bytes produced by one input byte, before they become words
  logic [7:0]  burst_bytes [PATTERN_MAX + REPLACE_MAX];
  int          burst_len;

  out_word_t   expected_words [$];

  // Move the oldest window byte out and slide the rest down
  task automatic release_oldest();
    int i;
    burst_bytes[burst_len] = window[0];
    burst_len++;
    for (i = 1; i < window_fill; i++) window[i-1] = window[i];
    window_fill--;
  endtask

  // Work out the words one text byte causes and queue them
  task automatic substitute_byte(input logic [7:0] text_byte, input logic end_of_text);
    int        plen;
    int        rlen;
    int        i;
    logic      same;
    logic      hit;
    out_word_t word;
    plen = (cfg.pattern_length > PATTERN_MAX) ? PATTERN_MAX : int'(cfg.pattern_length);
    rlen = (cfg.replacement_length > REPLACE_MAX) ? REPLACE_MAX
                                                   : int'(cfg.replacement_length);
    burst_len = 0;
    if (plen == 0) begin
      burst_bytes[0] = text_byte;
      burst_len = 1;
    end else begin
      if (window_fill >= plen) window_fill = 0;
      window[window_fill] = text_byte;
      window_fill++;
      if (window_fill == plen) begin
        same = 1'b1;
        for (i = 0; i < plen; i++) begin
          if (window[i] != cfg.pattern_bytes[8*i +: 8]) same = 1'b0;
        end
        hit = same && (cfg.instance_select == 16'd0 || cfg.instance_select == match_count);
        if (same && match_count != 16'hFFFF) match_count++;
        if (hit) begin
          for (i = 0; i < rlen; i++) begin
            burst_bytes[burst_len] = cfg.replacement_bytes[8*i +: 8];
            burst_len++;
          end
          window_fill = 0;
        end else begin
          release_oldest();
        end
      end
    end
    // Flush what is held and get ready for the next text
    if (end_of_text) begin
      while (window_fill > 0) release_oldest();
      match_count = 16'd1;
    end
    if (burst_len == 0 && end_of_text) begin
      word.out_byte   = 8'd0;
      word.byte_valid = 1'b0;
      word.run_last   = 1'b1;
      word.text_done  = 1'b1;
      expected_words.push_back(word);
    end
    for (i = 0; i < burst_len; i++) begin
      word.out_byte   = burst_bytes[i];
      word.byte_valid = 1'b1;
      word.run_last   = (i == burst_len - 1);
      word.text_done  = end_of_text && (i == burst_len - 1);
      expected_words.push_back(word);
    end
  endtask

  // Compare one word taken from the block with the oldest prediction
  task automatic check_word();
    out_word_t seen;
    out_word_t want;
    seen.out_byte   = m_tdata;
    seen.byte_valid = m_tuser[0];
    seen.run_last   = m_tlast;
    seen.text_done  = m_tuser[1];
    if (expected_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MISMATCH_REPORTS)
        $display("%0t: unexpected word byte=%h valid=%b last=%b done=%b", $realtime,
                 seen.out_byte, seen.byte_valid, seen.run_last, seen.text_done);
    end else begin
      want = expected_words.pop_front();
      if (seen !== want) begin
        mismatch_count++;
        if (mismatch_count <= MISMATCH_REPORTS) begin
          $write("%0t: word mismatch, expected byte=%h valid=%b last=%b done=%b,",
                 $realtime, want.out_byte, want.byte_valid, want.run_last,
                 want.text_done);
          $display(" got byte=%h valid=%b last=%b done=%b",
                   seen.out_byte, seen.byte_valid, seen.run_last, seen.text_done);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = '0;
      window_fill = 0;
      match_count = 16'd1;
      expected_words.delete();
    end else begin
      // The user must make register writes only while the block is idle; nothing here checks it.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:3]))
          REG_PATTERN_LENGTH: begin
            cfg.pattern_length = pwdata[3:0];
            window_fill = 0;
          end
          REG_PATTERN_BYTES:      cfg.pattern_bytes = pwdata;
          REG_REPLACEMENT_LENGTH: cfg.replacement_length = pwdata[3:0];
          REG_REPLACEMENT_BYTES:  cfg.replacement_bytes = pwdata;
          REG_INSTANCE_SELECT:    cfg.instance_select = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) substitute_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_word();
    end
    words_owed = expected_words.size();
  end

endmodule

// ===== verif/stream_substring_substitute_test.sv =====
// ----------------------------------------------------------------------------
// stream_substring_substitute_test
// Drives texts and register settings into the substring substitute block:
// a directed part for pass-through, matches, overlaps, deletion, the bare end
// marker and a window cleared by a length write, then random texts under
// random settings. Both stream sides idle at random until the last phase.
// Prediction and comparison live in sss_result_check.
// ----------------------------------------------------------------------------
module stream_substring_substitute_test;
  import sss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PATTERN_MAX    = 8;
  localparam int          REPLACE_MAX    = 8;
  localparam logic [2:0]  REG_UNMAPPED   = 3'd5;
  localparam int          RESET_CYCLES   = 11;
  localparam int          SETTLE_CYCLES  = 6;
  localparam int          CYCLE_LIMIT    = 60000;
  localparam int          RANDOM_PHASES  = 10;
  localparam int          PHASE_ITEMS    = 15;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = 8'd0;
  logic              s_tlast  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;
  logic [1:0]        m_tuser;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int          mismatch_count;
  int          words_owed;
  int          cycle_count = 0;
  int          stall_left  = 0;
  int          items_sent  = 0;
  bit          gaps_on     = 1'b1;
  bit          stall_on    = 1'b1;
  int          cur_plen    = 0;
  logic [63:0] cur_pat     = '0;

  always #6 clk = ~clk;

  stream_substring_substitute #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  sss_result_check #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) i_result_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .words_owed     (words_owed)
  );

  // Hold off the output side in random bursts while stalling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle; psel stays up for the next
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic release_bus();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int plen, input logic [63:0] pat, input int rlen,
                           input logic [63:0] rep, input logic [15:0] sel);
    write_reg(REG_PATTERN_LENGTH, 64'(plen));
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_REPLACEMENT_LENGTH, 64'(rlen));
    write_reg(REG_REPLACEMENT_BYTES, rep);
    write_reg(REG_INSTANCE_SELECT, 64'(sel));
    release_bus();
    cur_plen = plen;
    cur_pat  = pat;
  endtask

  // Offer one text byte, maybe after a short gap, and wait for it to be taken
  task automatic send_word(input logic [7:0] text_byte, input logic end_of_text);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= text_byte;
    s_tlast  <= end_of_text;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop sending until every predicted word is out, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Text built mostly from copies of the pattern, near misses and its bytes
  task automatic send_random_text();
    logic [7:0]  text_q [$];
    logic [63:0] pick;
    int          len;
    int          k;
    int          r;
    bit          terminate;
    len = $urandom_range(1, 20);
    while (text_q.size() < len) begin
      r = $urandom_range(0, 9);
      if (r < 5 && cur_plen > 0) begin
        pick = cur_pat;
        if (r == 4) pick = pick ^ (64'd1 << $urandom_range(0, 8 * cur_plen - 1));
        for (k = 0; k < cur_plen; k++) text_q.push_back(pick[8*k +: 8]);
      end else if (r < 7 && cur_plen > 0) begin
        text_q.push_back(cur_pat[8 * $urandom_range(0, cur_plen - 1) +: 8]);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    terminate = ($urandom_range(0, 7) != 0);
    for (k = 0; k < text_q.size(); k++)
      send_word(text_q[k], terminate && (k == text_q.size() - 1));
  endtask

  initial begin
    int          phase;
    int          start;
    int          plen;
    int          rlen;
    int          k;
    logic [63:0] pat;
    logic [63:0] rep;
    logic [15:0] sel;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings pass bytes straight through
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    drain();

    // Unmapped register is ignored; two-byte pattern, three-byte replacement
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    configure(2, 64'h6261, 3, 64'h5A5958, 16'd0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h78, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b1);
    drain();

    // Overlapping matches, only the second one deleted
    configure(2, 64'h6161, 0, {$urandom, $urandom}, 16'd2);
    for (k = 0; k < 4; k++) send_word(8'h61, k == 3);
    drain();

    // Text ending on a deleted match leaves only the end marker
    write_reg(REG_INSTANCE_SELECT, 64'd0);
    release_bus();
    send_word(8'h61, 1'b0);
    send_word(8'h61, 1'b1);
    drain();

    // Partly filled window is dropped by a pattern length write
    configure(8, 64'hFFFF_FFFF_FFFF_FFFF, 8, 64'h0123_4567_89AB_CDEF, 16'd0);
    for (k = 0; k < 3; k++) send_word(8'hFF, 1'b0);
    drain();
    write_reg(REG_PATTERN_LENGTH, 64'd8);
    release_bus();
    for (k = 0; k < 8; k++) send_word(8'hFF, k == 7);
    drain();

    // Random texts under a series of settings; the last phase runs without idling
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        plen = PATTERN_MAX;
        rlen = REPLACE_MAX;
        sel  = 16'd0;
      end else if (phase == 1) begin
        plen = 1;
        rlen = 0;
        sel  = 16'd1;
      end else begin
        plen = $urandom_range(0, PATTERN_MAX);
        rlen = $urandom_range(0, REPLACE_MAX);
        case ($urandom_range(0, 3))
          0:       sel = 16'd0;
          3:       sel = 16'($urandom_range(0, 65535));
          default: sel = 16'($urandom_range(1, 4));
        endcase
      end
      pat = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 1) begin
        for (k = 0; k < 8; k++) pat[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 1));
      end
      rep = {$urandom, $urandom};
      if (phase == RANDOM_PHASES - 1) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      configure(plen, pat, rlen, rep, sel);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        send_random_text();
        if ($urandom_range(0, 5) == 0) drain();
      end
      drain();
    end

    if (mismatch_count == 0 && words_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sss_pkg.sv
design/sss_cfg.sv
design/sss_front.sv
design/sss_queue.sv
design/sss_back.sv
design/stream_substring_substitute.sv
verif/sss_result_check.sv
verif/stream_substring_substitute_test.sv
